// ===== rtl/core/upd_pkg.sv =====
package upd_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam int unsigned MaxRes  = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_end;
  } out_item_t;

  // One classified input: up to three decoded bytes, oldest in slot 0.
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [1:0]             cnt;
    logic                   stream_end;
  } grp_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
    end else begin
      v = b - 8'h57;
    end
    hex_val = v[3:0];
  endfunction

endpackage

// ===== rtl/core/upd_front.sv =====
module upd_front
  import upd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_item_t item,
  output logic     grp_push,
  output grp_t     grp
);

  typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT} phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  logic [7:0] b;
  logic       fin;
  logic       plain_open;
  logic [7:0] plain_byte;
  logic [1:0] plain_cnt;

  assign b   = item.in_byte;
  assign fin = item.stream_end;

  // '%' opens an escape unless it is the final byte, then it goes out literally
  assign plain_open = (b == CH_PCT) && !fin;
  assign plain_byte = (b == CH_PLUS) ? CH_SPACE : b;
  assign plain_cnt  = plain_open ? 2'd0 : 2'd1;

  always_comb begin
    phase_nxt      = plain_open ? PH_PCT : PH_IDLE;
    held_nxt       = held_r;
    grp.bytes      = '0;
    grp.cnt        = plain_cnt;
    grp.stream_end = fin;
    unique case (phase_r)
      PH_IDLE: begin
        grp.bytes[0] = plain_byte;
      end
      PH_PCT: begin
        if (is_hex(b) && !fin) begin
          grp.cnt   = 2'd0;
          phase_nxt = PH_DIGIT;
          held_nxt  = b;
        end else begin
          grp.bytes[0] = CH_PCT;
          grp.bytes[1] = plain_byte;
          grp.cnt      = 2'd1 + plain_cnt;
        end
      end
      PH_DIGIT: begin
        if (is_hex(b)) begin
          grp.bytes[0] = {hex_val(held_r), hex_val(b)};
          grp.cnt      = 2'd1;
          phase_nxt    = PH_IDLE;
        end else begin
          // failed escape: '%', held digit, then the breaking byte
          grp.bytes[0] = CH_PCT;
          grp.bytes[1] = held_r;
          grp.bytes[2] = plain_byte;
          grp.cnt      = 2'd2 + plain_cnt;
        end
      end
      default: begin
        grp.bytes[0] = plain_byte;
      end
    endcase
  end

  assign grp_push = acc && (grp.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== rtl/core/upd_queue.sv =====
module upd_queue
  import upd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  grp_t wr_data,
  input  logic rd_en,
  output grp_t rd_data,
  output logic full,
  output logic empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

  grp_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == DepthC);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == LastIdx) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == LastIdx) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/upd_back.sv =====
module upd_back
  import upd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  grp_t      head,
  input  logic      head_empty,
  output logic      head_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  logic       vld_r;
  out_item_t  item_r;
  logic [1:0] idx_r;
  logic       load, last;

  assign empty    = !vld_r;
  assign out_item = item_r;

  // output register refills whenever the queue holds a group and the register is free or being drained this cycle
  assign load     = !head_empty && (!vld_r || pop);
  assign last     = (idx_r + 2'd1 == head.cnt);
  assign head_pop = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.out_byte <= head.bytes[idx_r];
      item_r.run_last <= last;
      item_r.out_end  <= last && head.stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= last ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        vld_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/url_percent_decoder.sv =====
// Path: an accepted byte's group is written into the group queue, then loaded into the
//   output register, from which it is popped.
// Throughput: one input transaction per cycle while the queue has room and each causes
//   at most one result (a failed escape gives up to 3); output drains a byte per cycle on pop.
// The group queue (QUEUE_DEPTH entries) is what lets input run ahead of a stalled output.
// Reset: synchronous, active low; clears the escape state, the queue and the output valid.
module url_percent_decoder
  import upd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  // Front: escape tracking and classification of every accepted byte into
  // a group of 0..3 decoded bytes. Groups with no bytes (a pending '%' or
  // first digit) never enter the queue.
  logic q_full, q_empty, grp_push, head_pop;
  grp_t grp, head;
  logic in_acc;

  // full tracks queue space only; the output side never blocks intake directly
  assign full   = q_full;
  assign in_acc = push && !q_full;

  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .item     (in_item),
    .grp_push (grp_push),
    .grp      (grp)
  );

  // Queue between front and back: each side stalls on its own.
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (grp_push),
    .wr_data (grp),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: walks the head group one byte per cycle, while the output register is free or
  // being popped, into the output register, marking the last byte of each group and the end of stream.
  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_empty (q_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_item   (out_item)
  );

endmodule

// ===== tb/tb_url_percent_decoder.sv =====
module tb_url_percent_decoder;
  import upd_pkg::*;

  // Tracks the decoder's escape state from the accepted encoded bytes and keeps the
  // decoded bytes still owed by the block, oldest first.
  class decode_scoreboard;
    typedef enum logic [1:0] {
      PH_NONE,
      PH_PCT,
      PH_DIGIT
    } esc_phase_e;

    esc_phase_e  phase;
    logic [7:0]  held_digit;
    out_item_t   expected_decoded[$];
    int unsigned n_errors;
    int unsigned n_encoded;
    int unsigned n_decoded;

    function new();
      phase      = PH_NONE;
      held_digit = 8'h00;
      n_errors   = 0;
      n_encoded  = 0;
      n_decoded  = 0;
    endfunction

    task report_mismatch(input string msg);
      if (n_errors < 25) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
      n_errors++;
    endtask

    // Returns 1 for 0-9, A-F, a-f and puts the nibble value in v.
    function bit hex_digit(input logic [7:0] b, output logic [3:0] v);
      v = 4'h0;
      if (b >= 8'h30 && b <= 8'h39) begin
        v = 4'(b - 8'h30);
        return 1'b1;
      end
      if (b >= 8'h41 && b <= 8'h46) begin
        v = 4'(b - 8'h41 + 8'd10);
        return 1'b1;
      end
      if (b >= 8'h61 && b <= 8'h66) begin
        v = 4'(b - 8'h61 + 8'd10);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Byte seen with no escape pending: may open one instead of producing a byte.
    function void decode_plain(input logic [7:0] b, input logic last_in,
                               ref logic [7:0] run[$]);
      if (b == CH_PCT) begin
        if (last_in) begin
          run.push_back(CH_PCT);
        end else begin
          phase = PH_PCT;
        end
      end else if (b == CH_PLUS) begin
        run.push_back(CH_SPACE);
      end else begin
        run.push_back(b);
      end
    endfunction

    function void note_encoded(input in_item_t it);
      logic [7:0] run[$];
      logic [3:0] hi_nib;
      logic [3:0] lo_nib;
      esc_phase_e prev;
      bit         lo_ok;
      out_item_t  r;

      n_encoded++;
      prev  = phase;
      phase = PH_NONE;
      lo_ok = hex_digit(it.in_byte, lo_nib);
      case (prev)
        PH_PCT: begin
          if (lo_ok && !it.stream_end) begin
            held_digit = it.in_byte;
            phase      = PH_DIGIT;
          end else begin
            run.push_back(CH_PCT);
            decode_plain(it.in_byte, it.stream_end, run);
          end
        end
        PH_DIGIT: begin
          if (lo_ok) begin
            void'(hex_digit(held_digit, hi_nib));
            run.push_back({hi_nib, lo_nib});
          end else begin
            // failed escape: '%' and the held digit come out literally
            run.push_back(CH_PCT);
            run.push_back(held_digit);
            decode_plain(it.in_byte, it.stream_end, run);
          end
          held_digit = 8'h00;
        end
        default: begin
          decode_plain(it.in_byte, it.stream_end, run);
        end
      endcase
      if (it.stream_end) begin
        phase      = PH_NONE;
        held_digit = 8'h00;
      end
      foreach (run[i]) begin
        r.out_byte = run[i];
        r.run_last = (i == run.size() - 1);
        r.out_end  = (i == run.size() - 1) && it.stream_end;
        expected_decoded.push_back(r);
      end
    endfunction

    task check_decoded(input out_item_t got);
      out_item_t want;
      n_decoded++;
      if (expected_decoded.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h (run_last %0b, out_end %0b)",
                                  got.out_byte, got.run_last, got.out_end));
      end else begin
        want = expected_decoded.pop_front();
        if (got.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("byte #%0d out_byte %02h, want %02h",
                                    n_decoded, got.out_byte, want.out_byte));
        end
        if (got.run_last !== want.run_last) begin
          report_mismatch($sformatf("byte #%0d run_last %0b, want %0b",
                                    n_decoded, got.run_last, want.run_last));
        end
        if (got.out_end !== want.out_end) begin
          report_mismatch($sformatf("byte #%0d out_end %0b, want %0b",
                                    n_decoded, got.out_end, want.out_end));
        end
      end
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  decode_scoreboard sb;

  // quiet: final stretch with no idling on either side
  bit          quiet;
  bit          held_off;
  int unsigned n_streams;

  url_percent_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit: bounds the worst case of roughly 200 bytes with idle gaps, stalled results
  // and the long hold-off, with a wide margin.
  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: every popped transaction goes straight to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      sb.check_decoded(out_item);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off once traffic is flowing
  // so the group queue fills and the block has to push back with full.
  initial begin
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_off && sb.n_decoded >= 40) begin
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (80) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // One encoded byte; push stays high across back-to-back transactions.
  task automatic send_byte(input logic [7:0] b, input logic last_in);
    in_item_t it;
    it.in_byte    = b;
    it.stream_end = last_in;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk);
    end
    @(negedge clk);
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note_encoded(it);
  endtask

  // Sends a whole stream; the last byte carries the end flag.
  task automatic send_stream(input logic [7:0] bytes_q[$]);
    foreach (bytes_q[i]) begin
      send_byte(bytes_q[i], i == bytes_q.size() - 1);
    end
    n_streams++;
  endtask

  function automatic logic [7:0] pick_hex();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) begin
      return 8'h30 + 8'(v);
    end
    // letters in either case
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // Well-formed escapes with random digits are the most common part; the rest is '+', raw noise and
  // broken or truncated escapes (which may land on the end of the stream).
  task automatic send_random_stream();
    logic [7:0]  q[$];
    int unsigned n_parts;
    int unsigned kind;
    n_parts = $urandom_range(1, 8);
    repeat (n_parts) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        q.push_back(CH_PCT);
        q.push_back(pick_hex());
        q.push_back(pick_hex());
      end else if (kind < 55) begin
        q.push_back(CH_PLUS);
      end else if (kind < 62) begin
        q.push_back(CH_PCT);
        q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 69) begin
        q.push_back(CH_PCT);
        q.push_back(pick_hex());
        q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 74) begin
        // truncated: whatever follows decides whether it completes or breaks
        q.push_back(CH_PCT);
        if ($urandom_range(0, 1)) begin
          q.push_back(pick_hex());
        end
      end else if (kind < 80) begin
        q.push_back(pick_hex());
      end else begin
        q.push_back(8'($urandom_range(0, 255)));
      end
    end
    send_stream(q);
  endtask

  initial begin
    int unsigned drain_cycles;
    sb        = new();
    quiet     = 1'b0;
    held_off  = 1'b0;
    n_streams = 0;
    rst_n     = 1'b0;
    push      = 1'b0;
    in_item   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: '+', byte extremes, good escapes in both cases, ending on a digit.
    send_stream('{CH_PLUS, 8'h00, 8'hFF, CH_PCT, 8'h34, 8'h31, CH_PCT, 8'h66, 8'h46,
                  CH_PCT, 8'h61, 8'h30});
    // Failed escapes: break on the first byte, on the second byte, and a '%' that
    // breaks an escape and opens a new one ("%%25").
    send_stream('{CH_PCT, 8'h47, CH_PCT, 8'h33, 8'h78, CH_PCT, CH_PCT, 8'h32, 8'h35});
    // End of stream with an escape pending at each depth.
    send_stream('{CH_PCT});
    send_stream('{CH_PCT, 8'h37});
    send_stream('{CH_PCT, 8'h42, CH_PCT});

    while (sb.n_encoded < 170) begin
      if (sb.n_encoded >= 140) begin
        quiet = 1'b1;
      end
      send_random_stream();
    end
    @(negedge clk);
    push <= 1'b0;

    // Drain, bounded; anything still owed after that is a failure.
    drain_cycles = 0;
    while (sb.expected_decoded.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);
    if (sb.expected_decoded.size() != 0) begin
      sb.report_mismatch($sformatf("%0d decoded bytes never arrived",
                                   sb.expected_decoded.size()));
    end

    $display("Covered %0d streams: %0d encoded bytes in, %0d decoded bytes checked.",
             n_streams, sb.n_encoded, sb.n_decoded);
    $display("Included good and broken escapes, end-of-stream flushes and a full-queue stall.");
    if (sb.n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/upd_pkg.sv
rtl/core/upd_front.sv
rtl/core/upd_queue.sv
rtl/core/upd_back.sv
rtl/core/url_percent_decoder.sv
tb/tb_url_percent_decoder.sv
